@@ hdl/bounded_random_from_lfsr_bank_top_macros.svh @@
// Assertion macros shared by the bounded random block.
`ifndef BOUNDED_RANDOM_FROM_LFSR_BANK_TOP_MACROS_SVH
`define BOUNDED_RANDOM_FROM_LFSR_BANK_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on the rising clock edge, idle while reset is low.
`define BRLB_ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Check a property on the rising clock edge, also during reset.
`define BRLB_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define BRLB_ASSERT_RST(label, clk, rst_n, prop)
`define BRLB_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

@@ hdl/brlb_pkg.sv @@
package brlb_pkg;

    localparam int NUM_SEQUENCES = 16;
    localparam int SEQ_W         = 31;
    localparam int VALUE_W       = 16;
    localparam int SEED_W        = 32;
    localparam int IDX_W         = (NUM_SEQUENCES > 1) ? $clog2(NUM_SEQUENCES) : 1;
    localparam int MAX_ROUNDS    = 256;
    localparam int ROUND_W       = $clog2(MAX_ROUNDS);

    localparam logic [31:0] LCG_MUL = 32'd2147437301;
    localparam logic [31:0] LCG_ADD = 32'd453816981;

    // Feedback taps of each sequence, one degree-31 primitive polynomial each
    localparam logic [31:0] FEEDBACK_POLY [16] = '{
        32'h00000004, 32'h00000007, 32'h00001084, 32'h00100807,
        32'h000A0054, 32'h0008401C, 32'h0000808E, 32'h00064402,
        32'h04020228, 32'h20081820, 32'h0201001A, 32'h04444444,
        32'h01042047, 32'h0060604C, 32'h02040166, 32'h0000585C
    };

    typedef enum logic {
        OP_GENERATE = 1'b0,
        OP_RESEED   = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_IDLE  = 3'b010,
        ST_ROUND = 3'b100
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic             capture;
        logic             load_en;
        logic [IDX_W-1:0] load_idx;
        logic             step_en;
        logic             out_load;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic cand_ok;
    } status_t;

    // One step of the seeding recurrence, low 31 bits only
    function automatic logic [SEQ_W-1:0] lcg_next(input logic [SEQ_W-1:0] x);
        logic [SEQ_W-1:0] prod;
        prod = x * LCG_MUL[SEQ_W-1:0];
        return prod + LCG_ADD[SEQ_W-1:0];
    endfunction

    // Ones at and below the highest set bit, at least bit 0
    function automatic logic [VALUE_W-1:0] bit_mask(input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] m;
        m = v;
        m = m | (m >> 1);
        m = m | (m >> 2);
        m = m | (m >> 4);
        m = m | (m >> 8);
        return m | VALUE_W'(1);
    endfunction

endpackage

@@ hdl/brlb_ctrl.sv @@
`include "bounded_random_from_lfsr_bank_top_macros.svh"

module brlb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  brlb_pkg::opcode_t opcode,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  brlb_pkg::status_t status,
    output brlb_pkg::cmd_t    cmd
);
    import brlb_pkg::*;

    localparam logic [IDX_W-1:0]   IDX_LAST   = IDX_W'(NUM_SEQUENCES - 1);
    localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(MAX_ROUNDS - 1);

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    // Sequence the reseed sweep and the rejection rounds
    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        round_next     = round_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        cmd.load_idx   = idx_reg;
        unique case (state_reg)
            ST_LOAD: begin
                cmd.load_en = 1'b1;
                idx_next    = idx_reg + 1'b1;
                if (idx_reg == IDX_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    if (opcode == OP_RESEED) begin
                        idx_next   = '0;
                        state_next = ST_LOAD;
                    end else begin
                        round_next = '0;
                        state_next = ST_ROUND;
                    end
                end
            end
            ST_ROUND: begin
                if (out_free) begin
                    cmd.step_en = 1'b1;
                    if (status.cand_ok || round_reg == ROUND_LAST) begin
                        cmd.out_load   = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end else begin
                        round_next = round_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state; after reset run the sweep that seeds with zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            idx_reg       <= '0;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `BRLB_ASSERT_RST(a_load_into_free_slot, aclk, aresetn,
        cmd.out_load |-> (!out_valid_reg || m_tready))
    `BRLB_ASSERT_RST(a_load_shows_result, aclk, aresetn,
        cmd.out_load |=> out_valid_reg)
    `BRLB_ASSERT_RST(a_sweep_starts_at_zero, aclk, aresetn,
        (state_reg != ST_LOAD) ##1 (state_reg == ST_LOAD) |-> (idx_reg == '0))
    `BRLB_ASSERT_RST(a_round_ends_in_idle, aclk, aresetn,
        (state_reg == ST_ROUND) |=> (state_reg == ST_ROUND || state_reg == ST_IDLE))

endmodule

@@ hdl/brlb_dp.sv @@
module brlb_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [brlb_pkg::VALUE_W-1:0]  max_value,
    input  logic [brlb_pkg::SEED_W-1:0]   seed,
    input  brlb_pkg::cmd_t                cmd,
    output brlb_pkg::status_t             status,
    output logic [brlb_pkg::VALUE_W-1:0]  value
);
    import brlb_pkg::*;

    logic [SEQ_W-1:0]   seq_reg [NUM_SEQUENCES];
    logic [SEQ_W-1:0]   step_val [NUM_SEQUENCES];
    logic [SEQ_W-1:0]   lcg_reg;
    logic [SEQ_W-1:0]   lcg_val;
    logic [VALUE_W-1:0] max_reg;
    logic [VALUE_W-1:0] mask_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] cand;

    assign lcg_val = lcg_next(lcg_reg);

    // Form the candidate from the top bits and the stepped lanes
    always_comb begin
        cand = '0;
        for (int i = 0; i < NUM_SEQUENCES; i++) begin
            cand[i] = seq_reg[i][SEQ_W-1] & mask_reg[i];
            if (seq_reg[i][SEQ_W-1]) begin
                step_val[i] = {seq_reg[i][SEQ_W-2:0] ^ FEEDBACK_POLY[i][SEQ_W-2:0], 1'b1};
            end else begin
                step_val[i] = {seq_reg[i][SEQ_W-2:0], 1'b0};
            end
        end
    end

    assign status.cand_ok = (cand <= max_reg);
    assign value          = value_reg;

    // Seeding recurrence state; reset seeds with zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lcg_reg <= '0;
        end else if (cmd.capture) begin
            lcg_reg <= seed[SEQ_W-1:0];
        end else if (cmd.load_en) begin
            lcg_reg <= lcg_val;
        end
    end

    // Capture the bound and the lanes it needs
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            max_reg  <= max_value;
            mask_reg <= bit_mask(max_value);
        end
    end

    // Load one sequence per sweep cycle, or step the active lanes
    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_SEQUENCES; i++) begin
            if (cmd.load_en && cmd.load_idx == IDX_W'(i)) begin
                seq_reg[i] <= lcg_val;
            end else if (cmd.step_en && mask_reg[i]) begin
                seq_reg[i] <= step_val[i];
            end
        end
    end

    // Register the result; fall back to the bound when rounds run out
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            value_reg <= status.cand_ok ? cand : max_reg;
        end
    end

endmodule

@@ hdl/bounded_random_from_lfsr_bank_top.sv @@
// Bounded random value generator over a bank of sixteen 31-bit Galois
// shift-register sequences.
// Input channel (s_): tuser selects the operation, generate or reseed; tdata
// carries the bound and the seed. Reseed gives no result transfer, generate
// gives exactly one on the result channel (m_), a value in 0..bound.
// Generate: the transfer is taken, then rejection rounds run (all active
// sequences step together) until a candidate is in range or the rounds run
// out; about 2 rounds on average, at most 256. The result is in the output
// register in the cycle after the last round.
// Reseed: the transfer is taken, then the sixteen sequences are loaded, one
// sequence per cycle, limited by the single seeding multiplier.
// Reset: a sweep seeds the bank with zero; s_tready stays low during it.
// A stalled receiver holds the finished result in the output register; the next
// item is still taken, and its rounds, the first one included, wait until that
// register frees.
module bounded_random_from_lfsr_bank_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // max_value[15:0], seed[47:16]
    input  logic [0:0]  s_tuser,   // opcode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // value[15:0]
);
    import brlb_pkg::*;

    cmd_t    cmd;
    status_t status;
    opcode_t opcode;

    assign opcode = opcode_t'(s_tuser[0]);

    brlb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .opcode   (opcode),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    brlb_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .max_value (s_tdata[VALUE_W-1:0]),
        .seed      (s_tdata[VALUE_W+SEED_W-1:VALUE_W]),
        .cmd       (cmd),
        .status    (status),
        .value     (m_tdata)
    );

endmodule
